[rtl/core/pfa_pkg.sv]
// shared constants, codes and word types for the partition fit allocator
package pfa_pkg;

    localparam int MAX_PARTITIONS = 32;
    localparam int SIZE_BITS      = 16;
    localparam int SLOT_BITS      = $clog2(MAX_PARTITIONS);
    localparam int USED_BITS      = $clog2(MAX_PARTITIONS + 1);
    localparam int COUNT_BITS     = 6;
    localparam int CFG_DATA_BITS  = 6;
    localparam int CFG_INDEX_BITS = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIT_POLICY      = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PARTITION_COUNT = 1'd1;

    // fit policy codes, the unused code behaves as first fit
    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST  = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef struct packed {
        logic        command;
        logic [4:0]  slot_index;
        logic [15:0] request_size;
    } pfa_item_t;

    typedef struct packed {
        logic        granted;
        logic [4:0]  chosen_slot;
        logic [15:0] size_before;
    } pfa_result_t;

endpackage

[rtl/core/partition_fit_allocator.sv]
// top level of the partition fit allocator: sequencer, scan unit and result register
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+------------------------------
//  command   | start, busy, item                       | word taken when start & !busy
//  result    | done, result                            | word shown one cycle with done
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data | written when valid & ready
//
// a load word does one memory read for the old size, then one write back
// an allocate word does one memory read per slot in use (saturated to 32) through
// the single read port, then a commit step; with no slot in use it goes straight to commit
// the result register is loaded on the last cycle, done is high the cycle after
// reset clears the policy, the count and all slot valid bits; an invalid slot reads as zero
// the receiver cannot stall, so busy only reflects the word in progress
module partition_fit_allocator
    import pfa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  pfa_item_t                 item,
    output logic                      done,
    output pfa_result_t               result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // one-hot sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOAD   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [1:0]            policy_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [USED_BITS-1:0]  used_slots;

    // latched command word
    logic [4:0]           slot_reg, slot_next;
    logic [SIZE_BITS-1:0] req_reg, req_next;

    // scan bookkeeping
    logic [SLOT_BITS-1:0] scan_idx_reg, scan_idx_next;
    logic                 found_reg, found_next;
    logic [SLOT_BITS-1:0] best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0] best_size_reg, best_size_next;

    // slot valid bits, an entry never written reads as zero
    logic [MAX_PARTITIONS-1:0] valid_reg;
    logic                      rd_valid_reg;

    // memory port
    logic                 ram_wr_en;
    logic [SLOT_BITS-1:0] ram_wr_addr;
    logic [SIZE_BITS-1:0] ram_wr_data;
    logic [SLOT_BITS-1:0] ram_rd_addr;
    logic [SIZE_BITS-1:0] ram_rd_data;
    logic [SIZE_BITS-1:0] cur_size;

    // result register
    logic        done_reg, done_next;
    pfa_result_t result_reg, result_next;

    logic slot_in_range;
    logic take;
    logic last_slot;
    logic grant;

    pfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_PARTITIONS)
    ) u_size_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // configuration port never back-pressures
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIRST;
            count_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FIT_POLICY:      policy_reg <= cfg_data[1:0];
                CFG_PARTITION_COUNT: count_reg  <= cfg_data[COUNT_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // counts above the table depth saturate
    assign used_slots = (USED_BITS'(count_reg) > USED_BITS'(MAX_PARTITIONS))
                      ? USED_BITS'(MAX_PARTITIONS) : USED_BITS'(count_reg);

    assign cur_size  = rd_valid_reg ? ram_rd_data : '0;
    assign last_slot = (USED_BITS'(scan_idx_reg) + USED_BITS'(1)) == used_slots;
    assign slot_in_range = ({1'b0, slot_reg} < 6'(MAX_PARTITIONS));

    // candidate test for the slot whose size is on the read port
    always_comb
    begin
        case (policy_reg)
            POLICY_WORST: take = !found_reg || (cur_size > best_size_reg);
            POLICY_BEST:  take = (cur_size >= req_reg)
                              && (!found_reg || (cur_size < best_size_reg));
            default:      take = (cur_size >= req_reg) && !found_reg;
        endcase
    end

    // worst fit may pick a slot that is too small
    assign grant = found_reg && (best_size_reg >= req_reg);

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        req_next       = req_reg;
        scan_idx_next  = scan_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_size_next = best_size_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = best_idx_reg;
        ram_wr_data    = best_size_reg - req_reg;
        ram_rd_addr    = scan_idx_reg + SLOT_BITS'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_rd_addr = '0;
                if (start)
                begin
                    slot_next      = item.slot_index;
                    req_next       = SIZE_BITS'(item.request_size);
                    scan_idx_next  = '0;
                    found_next     = 1'b0;
                    best_idx_next  = '0;
                    best_size_next = '0;
                    if (item.command == CMD_LOAD)
                    begin
                        ram_rd_addr = SLOT_BITS'(item.slot_index);
                        state_next  = ST_LOAD;
                    end
                    else if (used_slots == '0)
                    begin
                        // nothing in use: straight to a refusal
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_LOAD:
            begin
                done_next = 1'b1;
                result_next.chosen_slot = slot_reg;
                if (slot_in_range)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = SLOT_BITS'(slot_reg);
                    ram_wr_data = req_reg;
                    result_next.granted     = 1'b1;
                    result_next.size_before = 16'(cur_size);
                end
                else
                begin
                    result_next.granted     = 1'b0;
                    result_next.size_before = '0;
                end
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                if (take)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = scan_idx_reg;
                    best_size_next = cur_size;
                end
                scan_idx_next = scan_idx_reg + SLOT_BITS'(1);
                if (last_slot)
                begin
                    state_next = ST_COMMIT;
                end
            end

            ST_COMMIT:
            begin
                done_next = 1'b1;
                if (grant)
                begin
                    ram_wr_en = 1'b1;
                    result_next.granted     = 1'b1;
                    result_next.chosen_slot = 5'(best_idx_reg);
                    result_next.size_before = 16'(best_size_reg);
                end
                else
                begin
                    result_next.granted     = 1'b0;
                    result_next.chosen_slot = '0;
                    result_next.size_before = '0;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            rd_valid_reg <= valid_reg[ram_rd_addr];
            if (ram_wr_en)
            begin
                valid_reg[ram_wr_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        req_reg       <= req_next;
        scan_idx_reg  <= scan_idx_next;
        found_reg     <= found_next;
        best_idx_reg  <= best_idx_next;
        best_size_reg <= best_size_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/core/pfa_ram.sv]
// generic single-port-write ram with registered read
module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[verif/tb_partition_fit_allocator.sv]
// self-checking testbench for the partition fit allocator
`timescale 1ns / 100ps

module tb_partition_fit_allocator;
    import pfa_pkg::*;

    // policy code with no meaning of its own, it must behave as first fit
    localparam logic [1:0] POLICY_SPARE = 2'd3;
    // settle time, long enough for an allocate word and its done cycle
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 2000;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int RANDOM_PHASES = 21;
    localparam int PHASE_WORDS   = 50;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    pfa_item_t                 item;
    logic                      done;
    pfa_result_t               result;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // predictor state: remaining size per slot and the two registers
    logic [SIZE_BITS-1:0]  part_left [MAX_PARTITIONS];
    logic [1:0]            cur_policy;
    logic [COUNT_BITS-1:0] cur_count;

    // result words still owed by the block, oldest first
    pfa_result_t predicted_words [$];
    pfa_result_t want;

    int error_count;
    int cycle_count;
    int words_sent;
    int load_words;
    int grant_words;
    int refused_words;
    int cfg_writes;

    partition_fit_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // backstop against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("cycle limit reached with %0d words outstanding", predicted_words.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // number of slots the scan covers, the count register saturates at the table size
    function automatic int slots_in_use();
        return (cur_count > MAX_PARTITIONS) ? MAX_PARTITIONS : int'(cur_count);
    endfunction

    // works out the result word for one accepted word and updates the slot table
    function automatic pfa_result_t allocate_or_load(pfa_item_t w);
        pfa_result_t r;
        int          n;
        int          pick;
        bit          found;
        r     = '0;
        found = 1'b0;
        pick  = 0;
        if (w.command == CMD_LOAD)
        begin
            // every slot index is inside the table, so a load is always taken
            r.granted     = 1'b1;
            r.chosen_slot = w.slot_index;
            r.size_before = part_left[w.slot_index];
            part_left[w.slot_index] = w.request_size;
        end
        else
        begin
            n = slots_in_use();
            for (int i = 0; i < n; i++)
            begin
                if (cur_policy == POLICY_WORST)
                begin
                    // largest slot first, the fit test comes after the scan
                    if (!found || part_left[i] > part_left[pick])
                    begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
                else if (part_left[i] >= w.request_size)
                begin
                    if (cur_policy == POLICY_BEST)
                    begin
                        if (!found || part_left[i] < part_left[pick])
                        begin
                            pick  = i;
                            found = 1'b1;
                        end
                    end
                    else if (!found)
                    begin
                        // first fit, and the spare code acting as first fit
                        pick  = i;
                        found = 1'b1;
                    end
                end
            end
            if (found && cur_policy == POLICY_WORST && part_left[pick] < w.request_size)
                found = 1'b0;
            if (found)
            begin
                r.granted       = 1'b1;
                r.chosen_slot   = SLOT_BITS'(pick);
                r.size_before   = part_left[pick];
                part_left[pick] = part_left[pick] - w.request_size;
            end
        end
        return r;
    endfunction

    // compares each result word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (predicted_words.size() == 0)
            begin
                $error("result word with nothing expected: %p", result);
                error_count++;
            end
            else
            begin
                want = predicted_words.pop_front();
                if (result.granted !== want.granted)
                begin
                    $error("granted: expected %0d, got %0d", want.granted, result.granted);
                    error_count++;
                end
                if (result.chosen_slot !== want.chosen_slot)
                begin
                    $error("chosen_slot: expected %0d, got %0d",
                           want.chosen_slot, result.chosen_slot);
                    error_count++;
                end
                if (result.size_before !== want.size_before)
                begin
                    $error("size_before: expected %0d, got %0d",
                           want.size_before, result.size_before);
                    error_count++;
                end
            end
        end
    end

    // offers one word after a random gap (none when steady) and holds it until the block takes it;
    // start is left high after the accept; a park lowers it, as does a next call with a gap
    task automatic send_word(input pfa_item_t w, input bit steady);
        int          gap;
        pfa_result_t r;
        gap = steady ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            item  <= pfa_item_t'($bits(pfa_item_t)'($urandom));
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= w;
        do @(posedge clk); while (busy);
        r = allocate_or_load(w);
        predicted_words.push_back(r);
        words_sent++;
        if (w.command == CMD_LOAD)
            load_words++;
        else if (r.granted)
            grant_words++;
        else
            refused_words++;
    endtask

    // drops start, waits for every owed word, then lets the pipeline settle
    task automatic wait_idle();
        int waited;
        waited = 0;
        @(negedge clk);
        start <= 1'b0;
        while (predicted_words.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        if (predicted_words.size() != 0)
        begin
            $error("%0d result words never arrived", predicted_words.size());
            error_count += predicted_words.size();
            predicted_words.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only ever issued with the block idle
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_FIT_POLICY)
            cur_policy = data[1:0];
        else
            cur_count = data;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'($urandom);
    endtask

    // policy write with the unused upper data bits set at random
    task automatic write_policy(input logic [1:0] pol);
        logic [CFG_DATA_BITS-1:0] data;
        data      = CFG_DATA_BITS'($urandom);
        data[1:0] = pol;
        write_register(CFG_FIT_POLICY, data);
    endtask

    function automatic pfa_item_t make_word(input logic cmd, input int slot, input int size);
        pfa_item_t w;
        w.command      = cmd;
        w.slot_index   = SLOT_BITS'(slot);
        w.request_size = SIZE_BITS'(size);
        return w;
    endfunction

    // sizes lean on the edges: empty, full, small and anything
    function automatic logic [SIZE_BITS-1:0] pick_load_size();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return SIZE_BITS'($urandom_range(0, 63));
            default: return SIZE_BITS'($urandom);
        endcase
    endfunction

    // requests are mostly tied to what the table holds so that grants are common
    function automatic logic [SIZE_BITS-1:0] pick_request();
        logic [SIZE_BITS-1:0] base;
        int                   n;
        n    = slots_in_use();
        base = part_left[(n == 0) ? $urandom_range(0, MAX_PARTITIONS - 1) : $urandom_range(0, n - 1)];
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return base;
            6:          return base - SIZE_BITS'($urandom_range(0, 7));
            7:          return base + 1'b1;
            default:    return SIZE_BITS'($urandom);
        endcase
    endfunction

    // nothing in use straight after reset, and fresh slots read as zero
    task automatic test_empty_table();
        send_word(make_word(CMD_ALLOC, 0, 0), 1'b0);
        send_word(make_word(CMD_LOAD, 31, 16'hFFFF), 1'b0);
        send_word(make_word(CMD_LOAD, 0, 40), 1'b0);
    endtask

    // the three policies on a small table with a tie and an empty slot
    task automatic test_fit_policies();
        write_register(CFG_PARTITION_COUNT, 6'd4);
        send_word(make_word(CMD_LOAD, 1, 0), 1'b0);
        send_word(make_word(CMD_LOAD, 2, 40), 1'b0);
        send_word(make_word(CMD_LOAD, 3, 16'hFFFF), 1'b0);
        // first fit: zero request on the first slot, then one just too big for slot 0
        send_word(make_word(CMD_ALLOC, 0, 0), 1'b0);
        send_word(make_word(CMD_ALLOC, 0, 41), 1'b0);
        // best fit: the empty slot takes a zero request, the 40/40 tie goes low
        write_policy(POLICY_BEST);
        send_word(make_word(CMD_ALLOC, 0, 0), 1'b0);
        send_word(make_word(CMD_ALLOC, 0, 30), 1'b0);
        send_word(make_word(CMD_ALLOC, 0, 40), 1'b0);
        // worst fit: refused when even the largest is short, exact fit of a full slot
        write_policy(POLICY_WORST);
        send_word(make_word(CMD_ALLOC, 0, 16'hFFFF), 1'b0);
        send_word(make_word(CMD_ALLOC, 0, 1000), 1'b0);
        send_word(make_word(CMD_LOAD, 3, 16'hFFFF), 1'b0);
        send_word(make_word(CMD_ALLOC, 0, 16'hFFFF), 1'b0);
    endtask

    // spare policy code, count saturation and the zero and one slot tables
    task automatic test_register_extremes();
        write_register(CFG_FIT_POLICY, {4'hF, POLICY_SPARE});
        send_word(make_word(CMD_ALLOC, 9, 5), 1'b0);
        write_register(CFG_PARTITION_COUNT, 6'd33);
        send_word(make_word(CMD_ALLOC, 0, 16'h8000), 1'b0);
        write_register(CFG_PARTITION_COUNT, 6'd63);
        write_policy(POLICY_WORST);
        send_word(make_word(CMD_ALLOC, 0, 1), 1'b0);
        write_register(CFG_PARTITION_COUNT, 6'd0);
        send_word(make_word(CMD_ALLOC, 0, 0), 1'b0);
        write_register(CFG_PARTITION_COUNT, 6'd1);
        write_policy(POLICY_BEST);
        send_word(make_word(CMD_ALLOC, 0, 0), 1'b0);
    endtask

    // phases of random traffic, each under its own policy and slot count:
    // reload the slots in use, then mostly allocations with a few stray loads
    task automatic test_random_phases();
        int        count_plan [8] = '{32, 1, 2, 0, 33, 63, 31, 3};
        int        n_cfg;
        int        used;
        bit        steady;
        pfa_item_t w;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 8)
                n_cfg = count_plan[p];
            else if ($urandom_range(0, 3) == 0)
                n_cfg = $urandom_range(0, 63);
            else
                n_cfg = $urandom_range(1, 12);
            write_register(CFG_PARTITION_COUNT, COUNT_BITS'(n_cfg));
            write_policy(2'(p));
            // some phases run back to back with no gaps at all
            steady = ($urandom_range(0, 3) == 0);
            used   = (n_cfg > MAX_PARTITIONS) ? MAX_PARTITIONS : n_cfg;
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if (k < used)
                    w = make_word(CMD_LOAD, k, int'(pick_load_size()));
                else if ($urandom_range(0, 3) == 0)
                    w = make_word(CMD_LOAD, $urandom_range(0, MAX_PARTITIONS - 1),
                                  int'(pick_load_size()));
                else
                    w = make_word(CMD_ALLOC, $urandom_range(0, MAX_PARTITIONS - 1),
                                  int'(pick_request()));
                send_word(w, steady);
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cur_policy  = POLICY_FIRST;
        cur_count   = '0;
        error_count = 0;
        cycle_count = 0;
        for (int i = 0; i < MAX_PARTITIONS; i++)
            part_left[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_fit_policies();
        test_register_extremes();
        test_random_phases();
        wait_idle();

        $display("%0d words sent: %0d loads, %0d granted and %0d refused allocations",
                 words_sent, load_words, grant_words, refused_words);
        $display("%0d register writes over every policy code and counts from 0 to 63",
                 cfg_writes);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
